>>> sv/coulomb_energy_accumulator_unit_defines.svh
// ----------------------------------------------------------------------------
// Coulomb energy accumulator assertion macros
// Shared assertion forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef COULOMB_ENERGY_ACCUMULATOR_UNIT_DEFINES_SVH
`define COULOMB_ENERGY_ACCUMULATOR_UNIT_DEFINES_SVH

// implication checked every clock, off during reset
`define CEA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CEA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/cea_pkg.sv
// ----------------------------------------------------------------------------
// Coulomb energy accumulator package
// Widths, register indexes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none
package cea_pkg;
   localparam int FRAC_BITS = 16;
   localparam int POS_W     = 32;
   localparam int DIFF_W    = 33;
   localparam int SQ_W      = 68;
   localparam int ROOT_W    = 34;
   localparam int E_W       = 48;
   localparam int CHG_W     = 7;
   localparam int K_W       = 14;
   localparam int NUM_W     = K_W + 2 * FRAC_BITS;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] REG_CORE_X      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CORE_Y      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CORE_Z      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CORE_CHARGE = 2'd3;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_SQR  = 6'b000010,
      ST_ROOT = 6'b000100,
      ST_DIV  = 6'b001000,
      ST_ACC  = 6'b010000,
      ST_OUT  = 6'b100000
   } state_type;
endpackage
`default_nettype wire

>>> sv/coulomb_energy_accumulator_unit.sv
// ----------------------------------------------------------------------------
// Coulomb energy accumulator unit
// Sums the Coulomb energy of one configured nucleus against a particle stream.
// ----------------------------------------------------------------------------
// Usage:
//  - csr_*: write nucleus x/y/z (Q16.16) and charge Z while the unit is idle.
//  - req_*: one particle per transfer; mode 0 electron (-Z/r), mode 1 another
//    nucleus (+Z*Q/r). last=1 closes the sum and produces one rsp transfer.
//  - rsp_*: energy (signed Q32.16 Hartree), zero_distance, saturated.
// Timing:
//  - Each particle: squaring (one axis a cycle), then square root (one root
//    bit a cycle, trial square on the same 34x34 multiplier), then restoring
//    division (one quotient bit a cycle), then an accumulate step. rsp_valid
//    rises once the accumulate step of a last item is done. A zero distance
//    skips the division. The bit-serial root and divide take most of the time.
//  - req_ready is high only in idle; one item is in flight at a time.
//  - A result waits in rsp registers while rsp_ready is low; the next item is
//    taken only once the result transfer completes.
// Reset: synchronous; nucleus at origin, Z=1, sum and flags cleared.
// ----------------------------------------------------------------------------
`default_nettype none
`include "coulomb_energy_accumulator_unit_defines.svh"
module coulomb_energy_accumulator_unit
   import cea_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_we,
   input  wire logic [CSR_IDX_W-1:0]    csr_index,
   input  wire logic [POS_W-1:0]        csr_wdata,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic                    req_mode,
   input  wire logic signed [POS_W-1:0] req_pos_x,
   input  wire logic signed [POS_W-1:0] req_pos_y,
   input  wire logic signed [POS_W-1:0] req_pos_z,
   input  wire logic [CHG_W-1:0]        req_other_charge,
   input  wire logic                    req_last,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic signed [E_W-1:0]        rsp_energy,
   output logic                         rsp_zero_distance,
   output logic                         rsp_saturated
);
   localparam int CNT_W = 6;

   state_type state_ff, state_in;
   logic signed [POS_W-1:0] core_x_ff, core_y_ff, core_z_ff;
   logic [CHG_W-1:0]        core_chg_ff;
   logic [DIFF_W-1:0]       ax_ff, ay_ff, az_ff;
   logic [SQ_W-1:0]         sq_ff;       // sum of squares
   logic [ROOT_W-1:0]       root_ff;
   logic [NUM_W-1:0]        num_ff;      // dividend shifts out, quotient in
   logic [ROOT_W:0]         rem_ff;
   logic                    mode_ff, last_ff;
   logic [CNT_W-1:0]        cnt_ff;
   logic signed [E_W-1:0]   sum_ff;
   logic                    zero_ff, sat_ff;
   logic signed [E_W-1:0]   energy_ff;
   logic                    ozero_ff, osat_ff;

   // per-axis magnitude of the difference
   function automatic logic [DIFF_W-1:0] absd(input logic signed [POS_W-1:0] p,
                                             input logic signed [POS_W-1:0] c);
      logic signed [DIFF_W-1:0] d;
      d = DIFF_W'(p) - DIFF_W'(c);
      return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
   endfunction

   // shared multiplier: axis squares, then trial squares of the root
   logic [ROOT_W-1:0]   trial;
   logic [ROOT_W-1:0]   mul_a;
   logic [2*ROOT_W-1:0] mul_p;
   always_comb begin
      trial = root_ff | (ROOT_W'(1) << cnt_ff);
      if (state_ff == ST_ROOT) begin
         mul_a = trial;
      end else begin
         case (cnt_ff[1:0])
            2'd0:    mul_a = ROOT_W'(ax_ff);
            2'd1:    mul_a = ROOT_W'(ay_ff);
            default: mul_a = ROOT_W'(az_ff);
         endcase
      end
      mul_p = mul_a * mul_a;
   end

   // division step
   logic [ROOT_W+1:0] rem_sh;
   logic [ROOT_W+1:0] rem_sub;
   always_comb begin
      rem_sh  = {rem_ff, num_ff[NUM_W-1]};
      rem_sub = rem_sh - {2'b00, root_ff};
   end

   // accumulate
   logic [NUM_W-1:0]       quot;
   logic signed [E_W+1:0]  term, acc;
   always_comb begin
      quot = num_ff;
      term = mode_ff ? (E_W+2)'(quot) : -(E_W+2)'(quot);
      acc  = (E_W+2)'(sum_ff) + term;
   end
   localparam logic signed [E_W+1:0] E_MAX = (E_W+2)'({1'b0, {(E_W-1){1'b1}}});
   localparam logic signed [E_W+1:0] E_MIN = -E_MAX - 1;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_SQR;
         ST_SQR:  if (cnt_ff == CNT_W'(2)) state_in = ST_ROOT;
         ST_ROOT: if (cnt_ff == '0)
                     state_in = (mul_p <= sq_ff || root_ff != '0) ? ST_DIV : ST_ACC;
         ST_DIV:  if (cnt_ff == '0) state_in = ST_ACC;
         ST_ACC:  state_in = last_ff ? ST_OUT : ST_IDLE;
         ST_OUT:  if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         core_x_ff <= '0; core_y_ff <= '0; core_z_ff <= '0;
         core_chg_ff <= CHG_W'(1);
         sum_ff <= '0; zero_ff <= 1'b0; sat_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_index)
               REG_CORE_X:      core_x_ff   <= csr_wdata;
               REG_CORE_Y:      core_y_ff   <= csr_wdata;
               REG_CORE_Z:      core_z_ff   <= csr_wdata;
               REG_CORE_CHARGE: core_chg_ff <= csr_wdata[CHG_W-1:0];
               default: ;
            endcase
         end
         case (state_ff)
            ST_IDLE: begin
               cnt_ff <= '0;
               if (req_valid) begin
                  ax_ff   <= absd(req_pos_x, core_x_ff);
                  ay_ff   <= absd(req_pos_y, core_y_ff);
                  az_ff   <= absd(req_pos_z, core_z_ff);
                  mode_ff <= req_mode;
                  last_ff <= req_last;
                  sq_ff   <= '0;
                  root_ff <= '0;
                  num_ff  <= {(req_mode ? K_W'(core_chg_ff) * K_W'(req_other_charge)
                                        : K_W'(core_chg_ff)),
                              {(2*FRAC_BITS){1'b0}}};
               end
            end
            ST_SQR: begin
               sq_ff  <= sq_ff + mul_p;
               cnt_ff <= (cnt_ff == CNT_W'(2)) ? CNT_W'(ROOT_W-1) : cnt_ff + 1'b1;
            end
            ST_ROOT: begin
               if (mul_p <= sq_ff) root_ff <= trial;
               cnt_ff <= (cnt_ff == '0) ? CNT_W'(NUM_W-1) : cnt_ff - 1'b1;
               rem_ff <= '0;
            end
            ST_DIV: begin
               if (!rem_sub[ROOT_W+1]) begin
                  rem_ff <= rem_sub[ROOT_W:0];
                  num_ff <= {num_ff[NUM_W-2:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh[ROOT_W:0];
                  num_ff <= {num_ff[NUM_W-2:0], 1'b0};
               end
               cnt_ff <= cnt_ff - 1'b1;
            end
            ST_ACC: begin
               if (last_ff) begin
                  energy_ff <= (root_ff == '0) ? sum_ff :
                               (acc > E_MAX) ? E_MAX[E_W-1:0] :
                               (acc < E_MIN) ? E_MIN[E_W-1:0] : acc[E_W-1:0];
                  ozero_ff  <= zero_ff | (root_ff == '0);
                  osat_ff   <= sat_ff | (root_ff != '0 && (acc > E_MAX || acc < E_MIN));
                  sum_ff  <= '0;
                  zero_ff <= 1'b0;
                  sat_ff  <= 1'b0;
               end
               else if (root_ff == '0) zero_ff <= 1'b1;
               else if (acc > E_MAX) begin sum_ff <= E_MAX[E_W-1:0]; sat_ff <= 1'b1; end
               else if (acc < E_MIN) begin sum_ff <= E_MIN[E_W-1:0]; sat_ff <= 1'b1; end
               else sum_ff <= acc[E_W-1:0];
            end
            default: ;
         endcase
      end
   end

   assign req_ready         = (state_ff == ST_IDLE);
   assign rsp_valid         = (state_ff == ST_OUT);
   assign rsp_energy        = energy_ff;
   assign rsp_zero_distance = ozero_ff;
   assign rsp_saturated     = osat_ff;

   logic acc_last;
   assign acc_last = (state_ff == ST_ACC) && last_ff;

   `CEA_ASSERT_IMP(a_no_overlap, clock, reset, rsp_valid, !req_ready, "req taken, rsp pending")
   `CEA_ASSERT_NEXT(a_out_after_last, clock, reset, acc_last, rsp_valid, "last gave no result")
   `CEA_ASSERT_NEXT(a_sum_cleared, clock, reset, acc_last, sum_ff == '0 && !zero_ff && !sat_ff, "sum kept")
endmodule
`default_nettype wire
